FILE: rtl/mfh_pkg.sv
// shared types, constants and helpers for the folded murmur hash block
package mfh_pkg;

  localparam int LEN_W = 16;
  localparam int BITS_W = 6;
  localparam int IDX_W = 32;
  localparam int SH_W = 7;

  localparam logic [63:0] MUL_M = 64'hc6a4a7935bd1e995;
  localparam int SHIFT_R = 47;

  localparam logic [LEN_W-1:0] WORD_BYTES = LEN_W'(8);
  localparam logic [BITS_W-1:0] BITS_RESET = BITS_W'(16);
  localparam logic [BITS_W-1:0] BITS_MIN = BITS_W'(1);
  localparam logic [BITS_W-1:0] BITS_MAX = BITS_W'(32);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_DISP,
    ST_WORD,
    ST_KMIX,
    ST_ACC,
    ST_FIN,
    ST_FOLD,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    MS_LL,
    MS_LH,
    MS_HL
  } mul_step_t;

  typedef struct packed {
    logic        start;
    logic [63:0] x;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic              start;
    logic [63:0]       x;
    logic [BITS_W-1:0] bits;
  } fold_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] idx;
  } fold_rsp_t;

  function automatic logic [63:0] xorshift_r(input logic [63:0] v);
    return v ^ (v >> SHIFT_R);
  endfunction

  // mask of the low n bytes, n in 0..7
  function automatic logic [63:0] byte_mask(input logic [2:0] n);
    return (64'd1 << {n, 3'b000}) - 64'd1;
  endfunction

endpackage

FILE: rtl/mfh_mul.sv
// multiply by the mix constant, low 64 bits, from three 32x32 partial products
module mfh_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  mfh_pkg::mul_req_t req,
  output mfh_pkg::mul_rsp_t rsp
);

  logic [63:0]        x_r;
  logic [63:0]        p_r;
  logic               busy_r;
  logic               busy_nxt;
  logic               done_r;
  logic               done_nxt;
  mfh_pkg::mul_step_t step_r;
  mfh_pkg::mul_step_t step_nxt;
  logic [31:0]        op_a;
  logic [31:0]        op_b;
  logic [63:0]        product;

  always_comb begin
    unique case (step_r)
      mfh_pkg::MS_LL: begin
        op_a = x_r[31:0];
        op_b = mfh_pkg::MUL_M[31:0];
      end
      mfh_pkg::MS_LH: begin
        op_a = x_r[31:0];
        op_b = mfh_pkg::MUL_M[63:32];
      end
      mfh_pkg::MS_HL: begin
        op_a = x_r[63:32];
        op_b = mfh_pkg::MUL_M[31:0];
      end
      default: begin
        op_a = x_r[31:0];
        op_b = mfh_pkg::MUL_M[31:0];
      end
    endcase
  end

  assign product = {32'b0, op_a} * {32'b0, op_b};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    if (busy_r) begin
      unique case (step_r)
        mfh_pkg::MS_LL: step_nxt = mfh_pkg::MS_LH;
        mfh_pkg::MS_LH: step_nxt = mfh_pkg::MS_HL;
        mfh_pkg::MS_HL: begin
          step_nxt = mfh_pkg::MS_LL;
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
        default: step_nxt = mfh_pkg::MS_LL;
      endcase
    end else if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = mfh_pkg::MS_LL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= mfh_pkg::MS_LL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && req.start) begin
      x_r <= req.x;
    end
    if (busy_r) begin
      if (step_r == mfh_pkg::MS_LL) begin
        p_r <= product;
      end else begin
        // cross terms only reach the upper half
        p_r[63:32] <= p_r[63:32] + product[31:0];
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = p_r;

endmodule

FILE: rtl/mfh_fold.sv
// xor-fold of the 64-bit mix into an index, one arithmetic shift per cycle
module mfh_fold (
  input  logic               clk,
  input  logic               rst_n,
  input  mfh_pkg::fold_req_t req,
  output mfh_pkg::fold_rsp_t rsp
);

  logic [63:0]                 x_r;
  logic [63:0]                 j_r;
  logic [mfh_pkg::SH_W-1:0]    sh_r;
  logic [mfh_pkg::BITS_W-1:0]  b_r;
  logic [mfh_pkg::IDX_W-1:0]   idx_r;
  logic                        busy_r;
  logic                        done_r;
  logic [mfh_pkg::BITS_W-1:0]  b_clamp;
  logic [63:0]                 shifted;
  logic [63:0]                 idx_mask;

  always_comb begin
    priority if (req.bits < mfh_pkg::BITS_MIN) begin
      b_clamp = mfh_pkg::BITS_MIN;
    end else if (req.bits > mfh_pkg::BITS_MAX) begin
      b_clamp = mfh_pkg::BITS_MAX;
    end else begin
      b_clamp = req.bits;
    end
  end

  assign shifted  = 64'($signed(x_r) >>> sh_r[5:0]);
  assign idx_mask = (64'd1 << b_r) - 64'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        if (!sh_r[mfh_pkg::SH_W-1]) begin
          // sh_r stays below 64 while the top bit is clear
        end else begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (req.start) begin
        busy_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      if (!sh_r[mfh_pkg::SH_W-1]) begin
        j_r  <= j_r ^ shifted;
        sh_r <= sh_r + {1'b0, b_r};
      end else begin
        idx_r <= mfh_pkg::IDX_W'(j_r & idx_mask);
      end
    end else if (req.start) begin
      x_r  <= req.x;
      j_r  <= req.x;
      b_r  <= b_clamp;
      sh_r <= {1'b0, b_clamp};
    end
  end

  assign rsp.done = done_r;
  assign rsp.idx  = idx_r;

endmodule

FILE: rtl/murmur64_fold_hash.sv
// Streaming MurmurHash64A over 64-bit little-endian key words with an xor-folded
// table index. Every multiply by the mix constant runs on one shared 32x32
// multiplier as three partial products. An item is taken and then dispatched; a
// first item adds one multiply for the seed, a full 8-byte word costs three
// multiplies, a partial word one, and a word past the end of the key none. A last
// item adds the finalizing multiply, the xor-fold of the mix into the index and
// the load of the result into the output register. Input stall stays high while
// an item is in work; a result waits in the output register and the next item
// can be taken while it is still stalled. index_bits of 0 acts as 1 and values
// above 32 act as 32.
module murmur64_fold_hash (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [mfh_pkg::BITS_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_first_word,
  input  logic [15:0]                 in_key_length,
  input  logic [31:0]                 in_seed_tag,
  input  logic                        in_odd_step,
  input  logic [63:0]                 in_key_word,
  input  logic                        in_last_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [31:0]                 out_hash_index,
  output logic [63:0]                 out_mix_value
);

  mfh_pkg::state_t            state_r;
  mfh_pkg::state_t            state_nxt;
  logic [mfh_pkg::BITS_W-1:0] index_bits_r;
  logic [63:0]                acc_r;
  logic [mfh_pkg::LEN_W-1:0]  bytes_left_r;
  logic                       odd_flag_r;
  logic [mfh_pkg::LEN_W-1:0]  len_r;
  logic [31:0]                seed_r;
  logic                       odd_r;
  logic [63:0]                word_r;
  logic                       last_r;
  logic [63:0]                h_r;
  logic                       out_valid_r;
  logic [31:0]                out_idx_r;
  logic [63:0]                out_mix_r;

  mfh_pkg::mul_req_t          mul_req;
  mfh_pkg::mul_rsp_t          mul_rsp;
  mfh_pkg::fold_req_t         fold_req;
  mfh_pkg::fold_rsp_t         fold_rsp;

  logic                       in_take;
  logic                       out_free;
  logic                       out_load;
  logic                       has_full;
  logic                       has_part;
  logic [63:0]                fin_mix;

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign has_full = bytes_left_r >= mfh_pkg::WORD_BYTES;
  assign has_part = (bytes_left_r != '0) && !has_full;
  assign fin_mix  = mfh_pkg::xorshift_r(mul_rsp.prod);

  mfh_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  mfh_fold u_fold (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fold_req),
    .rsp   (fold_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mfh_pkg::ST_IDLE: begin
        if (in_take) begin
          state_nxt = in_first_word ? mfh_pkg::ST_SEED : mfh_pkg::ST_DISP;
        end
      end
      mfh_pkg::ST_SEED: begin
        if (mul_rsp.done) state_nxt = mfh_pkg::ST_DISP;
      end
      mfh_pkg::ST_DISP: begin
        priority if (has_full) begin
          state_nxt = mfh_pkg::ST_WORD;
        end else if (has_part) begin
          state_nxt = mfh_pkg::ST_ACC;
        end else if (last_r) begin
          state_nxt = mfh_pkg::ST_FIN;
        end else begin
          state_nxt = mfh_pkg::ST_IDLE;
        end
      end
      mfh_pkg::ST_WORD: begin
        if (mul_rsp.done) state_nxt = mfh_pkg::ST_KMIX;
      end
      mfh_pkg::ST_KMIX: begin
        if (mul_rsp.done) state_nxt = mfh_pkg::ST_ACC;
      end
      mfh_pkg::ST_ACC: begin
        if (mul_rsp.done) begin
          state_nxt = last_r ? mfh_pkg::ST_FIN : mfh_pkg::ST_IDLE;
        end
      end
      mfh_pkg::ST_FIN: begin
        if (mul_rsp.done) state_nxt = mfh_pkg::ST_FOLD;
      end
      mfh_pkg::ST_FOLD: begin
        if (fold_rsp.done) state_nxt = mfh_pkg::ST_OUT;
      end
      mfh_pkg::ST_OUT: begin
        if (out_free) state_nxt = mfh_pkg::ST_IDLE;
      end
      default: state_nxt = mfh_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall       = 1'b1;
    mul_req.start  = 1'b0;
    mul_req.x      = acc_r;
    fold_req.start = 1'b0;
    fold_req.x     = fin_mix;
    fold_req.bits  = index_bits_r;
    out_load       = 1'b0;
    unique case (state_r)
      mfh_pkg::ST_IDLE: begin
        in_stall      = 1'b0;
        mul_req.start = in_take && in_first_word;
        mul_req.x     = 64'(in_key_length[mfh_pkg::LEN_W-1:0]);
      end
      mfh_pkg::ST_SEED: begin
      end
      mfh_pkg::ST_DISP: begin
        priority if (has_full) begin
          mul_req.start = 1'b1;
          mul_req.x     = word_r;
        end else if (has_part) begin
          mul_req.start = 1'b1;
          mul_req.x     = acc_r ^ (word_r & mfh_pkg::byte_mask(bytes_left_r[2:0]));
        end else begin
          mul_req.start = last_r;
          mul_req.x     = mfh_pkg::xorshift_r(acc_r);
        end
      end
      mfh_pkg::ST_WORD: begin
        mul_req.start = mul_rsp.done;
        mul_req.x     = fin_mix;
      end
      mfh_pkg::ST_KMIX: begin
        mul_req.start = mul_rsp.done;
        mul_req.x     = acc_r ^ mul_rsp.prod;
      end
      mfh_pkg::ST_ACC: begin
        mul_req.start = mul_rsp.done && last_r;
        mul_req.x     = fin_mix;
      end
      mfh_pkg::ST_FIN: begin
        fold_req.start = mul_rsp.done;
      end
      mfh_pkg::ST_FOLD: begin
      end
      mfh_pkg::ST_OUT: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mfh_pkg::ST_IDLE;
      index_bits_r <= mfh_pkg::BITS_RESET;
      acc_r        <= '0;
      bytes_left_r <= '0;
      odd_flag_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) index_bits_r <= cfg_wr_data;
      if (state_r == mfh_pkg::ST_SEED && mul_rsp.done) begin
        acc_r        <= {32'b0, seed_r} ^ mul_rsp.prod;
        bytes_left_r <= len_r;
        odd_flag_r   <= odd_r;
      end
      if (state_r == mfh_pkg::ST_DISP && has_part) begin
        bytes_left_r <= '0;
      end
      if (state_r == mfh_pkg::ST_KMIX && mul_rsp.done) begin
        bytes_left_r <= bytes_left_r - mfh_pkg::WORD_BYTES;
      end
      if (state_r == mfh_pkg::ST_ACC && mul_rsp.done) begin
        acc_r <= mul_rsp.prod;
      end
      if (out_load) begin
        out_valid_r  <= 1'b1;
        bytes_left_r <= '0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request latch and result payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      len_r   <= in_key_length[mfh_pkg::LEN_W-1:0];
      seed_r  <= in_seed_tag;
      odd_r   <= in_odd_step;
      word_r  <= in_key_word;
      last_r  <= in_last_word;
    end
    if (fold_req.start) begin
      h_r <= fin_mix;
    end
    if (out_load) begin
      out_idx_r <= fold_rsp.idx | {31'b0, odd_flag_r};
      out_mix_r <= h_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hash_index = out_idx_r;
  assign out_mix_value  = out_mix_r;

endmodule

FILE: rtl/mfh_checker.sv
// port-level checks for the folded murmur hash block, bound to the top level
module mfh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_wr_en,
  input logic [5:0]  cfg_wr_data,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_first_word,
  input logic [15:0] in_key_length,
  input logic [31:0] in_seed_tag,
  input logic        in_odd_step,
  input logic [63:0] in_key_word,
  input logic        in_last_word,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_hash_index,
  input logic [63:0] out_mix_value
);

  // a taken request keeps the input closed for at least the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken back to back");

  // a new result only appears while the input is held off
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with input open");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_hash_index) && $stable(out_mix_value)))
    else $error("stalled result changed");

endmodule

bind murmur64_fold_hash mfh_checker u_mfh_checker (.*);
